[rtl/core/bpa_pkg.sv]
// Shared types, codes and defaults of the buddy page allocator.
`default_nettype none
package bpa_pkg;

    localparam int MEM_PAGES_DEF = 64;
    localparam int TAG_BITS_DEF  = 8;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NO_OWNER = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam logic [1:0] KIND_ABSENT = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_USED   = 2'd2;
    localparam logic [1:0] KIND_SPLIT  = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] owner_pid;
        logic [7:0] owner_tag;
        logic [6:0] req_size;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] start_page;
        logic [6:0] block_pages;
    } rsp_item_t;

endpackage
`default_nettype wire

[rtl/core/buddy_page_allocator.sv]
// Buddy page allocator: sequencer walking the node tree held in one memory.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | bpa_pkg::req_item_t
//  rsp     | out       | rsp_valid/rsp_stall | bpa_pkg::rsp_item_t
//
// One request at a time; each node visit is a memory read, then a decide step;
// a backtrack step moves up or to the right sibling, a split marks the node split and frees
// both children, and a merge step checks the buddy, clears node and buddy, frees the parent.
// After reset a clearing pass over every node runs before the first request is taken.
// A result waits in the output register; the next request is taken meanwhile.
`default_nettype none
module buddy_page_allocator #(
    parameter int MEM_PAGES = bpa_pkg::MEM_PAGES_DEF,
    parameter int TAG_BITS  = bpa_pkg::TAG_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire bpa_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output bpa_pkg::rsp_item_t      rsp
);

    localparam int LOG_M  = $clog2(MEM_PAGES);
    localparam int NODE_W = LOG_M + 1;
    localparam int SIZE_W = LOG_M + 1;
    localparam int CMP_W  = (SIZE_W > 7) ? SIZE_W : 7;
    localparam int WORD_W = 10 + TAG_BITS;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(2 * MEM_PAGES - 1);
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
    localparam logic [SIZE_W-1:0] FULL_SIZE = SIZE_W'(MEM_PAGES);

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b0000_0000_0001,
        S_IDLE    = 12'b0000_0000_0010,
        S_READ    = 12'b0000_0000_0100,
        S_EVAL    = 12'b0000_0000_1000,
        S_SPLIT_L = 12'b0000_0001_0000,
        S_SPLIT_R = 12'b0000_0010_0000,
        S_BACK    = 12'b0000_0100_0000,
        S_REL_RD  = 12'b0000_1000_0000,
        S_REL_EV  = 12'b0001_0000_0000,
        S_REL_W2  = 12'b0010_0000_0000,
        S_REL_W3  = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [NODE_W-1:0]    node_reg, node_next;
    logic [LOG_M-1:0]     start_reg, start_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [1:0]           status_reg, status_next;
    bpa_pkg::req_item_t   item_reg, item_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    bpa_pkg::rsp_item_t   rsp_reg, rsp_next;

    logic                 mem_we;
    logic [NODE_W-1:0]    mem_waddr;
    logic [1:0]           mem_wkind;
    logic [NODE_W-1:0]    mem_raddr;
    logic [WORD_W-1:0]    mem_rdata;

    logic [1:0]           rd_kind;
    logic [7:0]           rd_pid;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [TAG_BITS-1:0]  tag_in;
    logic [CMP_W-1:0]     req_cmp;
    logic [CMP_W-1:0]     size_cmp;
    logic [CMP_W-1:0]     half_cmp;
    logic                 fits;
    logic                 owner_hit;
    logic                 is_alloc;

    bpa_node_mem #(
        .ADDR_W (NODE_W),
        .WORD_W (WORD_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata ({mem_wkind, item_reg.owner_pid, tag_in}),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_kind   = mem_rdata[WORD_W-1 -: 2];
    assign rd_pid    = mem_rdata[TAG_BITS +: 8];
    assign rd_tag    = mem_rdata[TAG_BITS-1:0];
    assign tag_in    = TAG_BITS'(item_reg.owner_tag);
    assign req_cmp   = CMP_W'(item_reg.req_size);
    assign size_cmp  = CMP_W'(size_reg);
    assign half_cmp  = CMP_W'(size_reg >> 1);
    assign fits      = (req_cmp > half_cmp) && (req_cmp <= size_cmp);
    assign owner_hit = (rd_pid == item_reg.owner_pid) && (rd_tag == tag_in);
    assign is_alloc  = (item_reg.req_type == bpa_pkg::REQ_ALLOC);
    assign mem_raddr = (state_reg == S_REL_RD) ? (node_reg ^ ROOT) : node_reg;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        start_next     = start_reg;
        size_next      = size_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wkind      = bpa_pkg::KIND_FREE;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wkind = (node_reg == ROOT) ? bpa_pkg::KIND_FREE : bpa_pkg::KIND_ABSENT;
                if (node_reg == LAST_NODE)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    node_next = node_reg + NODE_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    node_next  = ROOT;
                    start_next = '0;
                    size_next  = FULL_SIZE;
                    if (req.req_type == bpa_pkg::REQ_ALLOC && req.req_size == 7'd0)
                    begin
                        status_next = bpa_pkg::ST_ZERO;
                        state_next  = S_DONE;
                    end
                    else if (req.req_type inside {bpa_pkg::REQ_ALLOC, bpa_pkg::REQ_FREE,
                                                  bpa_pkg::REQ_LOOKUP})
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        status_next = bpa_pkg::ST_NO_OWNER;
                        state_next  = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (rd_kind == bpa_pkg::KIND_SPLIT)
                begin
                    node_next  = node_reg << 1;
                    size_next  = size_reg >> 1;
                    state_next = S_READ;
                end
                else if (is_alloc)
                begin
                    state_next = S_BACK;
                    if (rd_kind == bpa_pkg::KIND_FREE && fits)
                    begin
                        mem_we      = 1'b1;
                        mem_wkind   = bpa_pkg::KIND_USED;
                        status_next = bpa_pkg::ST_OK;
                        state_next  = S_DONE;
                    end
                    else if (rd_kind == bpa_pkg::KIND_FREE && req_cmp <= half_cmp
                             && size_reg > SIZE_W'(1))
                    begin
                        mem_we     = 1'b1;
                        mem_wkind  = bpa_pkg::KIND_SPLIT;
                        state_next = S_SPLIT_L;
                    end
                end
                else
                begin
                    state_next = S_BACK;
                    if (rd_kind == bpa_pkg::KIND_USED && owner_hit)
                    begin
                        status_next = bpa_pkg::ST_OK;
                        if (item_reg.req_type == bpa_pkg::REQ_FREE)
                        begin
                            mem_we     = 1'b1;
                            mem_wkind  = bpa_pkg::KIND_FREE;
                            state_next = S_REL_RD;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_SPLIT_L:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg << 1;
                state_next = S_SPLIT_R;
            end
            S_SPLIT_R:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {node_reg[NODE_W-2:0], 1'b1};
                node_next  = node_reg << 1;
                size_next  = size_reg >> 1;
                state_next = S_READ;
            end
            S_BACK:
            begin
                if (node_reg == ROOT)
                begin
                    status_next = is_alloc ? bpa_pkg::ST_NO_FIT : bpa_pkg::ST_NO_OWNER;
                    state_next  = S_DONE;
                end
                else if (node_reg[0])
                begin
                    node_next  = node_reg >> 1;
                    start_next = start_reg - LOG_M'(size_reg);
                    size_next  = size_reg << 1;
                end
                else
                begin
                    node_next  = node_reg | ROOT;
                    start_next = start_reg + LOG_M'(size_reg);
                    state_next = S_READ;
                end
            end
            S_REL_RD:
            begin
                state_next = (node_reg == ROOT) ? S_DONE : S_REL_EV;
            end
            S_REL_EV:
            begin
                if (rd_kind == bpa_pkg::KIND_FREE)
                begin
                    mem_we     = 1'b1;
                    mem_wkind  = bpa_pkg::KIND_ABSENT;
                    state_next = S_REL_W2;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_REL_W2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg ^ ROOT;
                mem_wkind  = bpa_pkg::KIND_ABSENT;
                state_next = S_REL_W3;
            end
            S_REL_W3:
            begin
                mem_we     = 1'b1;
                mem_waddr  = node_reg >> 1;
                node_next  = node_reg >> 1;
                state_next = S_REL_RD;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = status_reg;
                    rsp_next.start_page  = (status_reg == bpa_pkg::ST_OK) ? 6'(start_reg) : 6'd0;
                    rsp_next.block_pages = (status_reg == bpa_pkg::ST_OK) ? 7'(size_reg) : 7'd0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            node_reg      <= '0;
            start_reg     <= '0;
            size_reg      <= '0;
            status_reg    <= bpa_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            start_reg     <= start_next;
            size_reg      <= size_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the done step");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall)
        else $error("request taken during clearing pass");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rsp_valid && rsp_stall) |=> (state_reg == S_DONE))
        else $error("result dropped while output held");

endmodule
`default_nettype wire

[rtl/core/bpa_node_mem.sv]
// Node store of the buddy tree: one write port, one registered read port.
`default_nettype none
module bpa_node_mem #(
    parameter int ADDR_W = 7,
    parameter int WORD_W = 18
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
